/* rtl/core/trle_pkg.sv */
package trle_pkg;

  // Payload widths
  localparam int DATA_W    = 8;
  localparam int INDEX_W   = 24;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 8;

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_TOP_FIRST = 3'd4;

  localparam int PB_W = 3;
  localparam logic [PB_W-1:0] PIXEL_BYTES_3 = 3'd3;
  localparam logic [PB_W-1:0] PIXEL_BYTES_4 = 3'd4;

  // Packet header fields
  localparam int RUN_FLAG_BIT = 7;
  localparam int RUN_LEN_W    = 7;

  localparam logic [VALUE_W-1:0] ACCUM_INIT = 32'hFFFF_FFFF;

endpackage

/* rtl/core/trle_byte_if.sv */
interface trle_byte_if;
  import trle_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

/* rtl/core/trle_pix_if.sv */
interface trle_pix_if;
  import trle_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] pixel_index;
  logic [VALUE_W-1:0] pixel_value;
  logic [COUNT_W-1:0] pixel_count;
  logic               image_done;
  logic               overrun;

  modport source (output valid, output pixel_index, output pixel_value, output pixel_count,
                  output image_done, output overrun, input ready);
  modport sink   (input valid, input pixel_index, input pixel_value, input pixel_count,
                  input image_done, input overrun, output ready);
endinterface

/* rtl/core/tga_rle_pixel_decoder_core.sv */
// Channel     Dir  Payload                                              Transaction
// ----------  ---  ---------------------------------------------------  ----------------
// byte_in     in   data_byte[7:0], start_of_image                       valid && ready
// pixel_out   out  pixel_index[23:0], pixel_value[31:0], pixel_count,   valid && ready
//                  image_done, overrun
// cfg_*       in   cfg_index[2:0], cfg_data[12:0]                       cfg_we
//
// One byte per cycle sustained while the output register is free or being taken. A byte
// sits in the input register, is decoded there against the packet/position state, and a
// result lands in the output register. The decode step holds while the output
// register is full and not being taken; byte_in.ready drops only then. rst is
// synchronous: it clears position/packet state and puts the header registers back to
// width 1, height 1, 4 bytes per pixel, raw mode, bottom-first rows.
module tga_rle_pixel_decoder_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [trle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trle_pkg::CFG_W-1:0]     cfg_data,
  trle_byte_if.sink                      byte_in,
  trle_pix_if.source                     pixel_out
);
  import trle_pkg::*;

  localparam int DW  = $clog2(MAX_DIM + 1);    // clamped width/height, row
  localparam int CLW = $clog2(MAX_DIM + 256);  // column can run past the row end
  localparam int TW  = 2 * DW;                 // width*height
  localparam int XW  = 2 * DW + 1;             // row base + column

  // ---------------- header registers ----------------
  logic [CFG_W-1:0] cfg_width, cfg_height;
  logic [PB_W-1:0]  cfg_pixel_bytes;
  logic             cfg_rle, cfg_top_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width       <= CFG_W'(1);
      cfg_height      <= CFG_W'(1);
      cfg_pixel_bytes <= PIXEL_BYTES_4;
      cfg_rle         <= 1'b0;
      cfg_top_first   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    cfg_width       <= cfg_data;
        REG_IMAGE_HEIGHT:   cfg_height      <= cfg_data;
        REG_PIXEL_BYTES:    cfg_pixel_bytes <= cfg_data[PB_W-1:0];
        REG_RLE_MODE:       cfg_rle         <= cfg_data[0];
        REG_ROWS_TOP_FIRST: cfg_top_first   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // dimensions saturate to 1..MAX_DIM
  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) return DW'(1);
    if (v32 > 32'(MAX_DIM)) return DW'(MAX_DIM);
    return DW'(v32);
  endfunction

  logic [DW-1:0] w_dim, h_dim;
  logic [TW-1:0] total;

  assign w_dim = clamp_dim(cfg_width);
  assign h_dim = clamp_dim(cfg_height);

  // Image size is only needed for clipping; config is static around a decode, so a
  // registered product keeps this multiplier off the decode path.
  always_ff @(posedge clk) begin
    total <= TW'(w_dim) * TW'(h_dim);
  end

  // ---------------- input register ----------------
  logic              st_valid;
  logic [DATA_W-1:0] st_byte;
  logic              st_sof;
  logic              adv;

  assign adv           = st_valid && (!pixel_out.valid || pixel_out.ready);
  assign byte_in.ready = !st_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (byte_in.ready) begin
      st_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      st_byte <= byte_in.data_byte;
      st_sof  <= byte_in.start_of_image;
    end
  end

  // ---------------- decode state ----------------
  logic               expect_header, packet_is_run, finished;
  logic [COUNT_W-1:0] packet_left;
  logic [1:0]         byte_index;
  logic [VALUE_W-1:0] pixel_accum;
  logic [CLW-1:0]     column;
  logic [DW-1:0]      row;

  logic               expect_header_next, packet_is_run_next, finished_next;
  logic [COUNT_W-1:0] packet_left_next;
  logic [1:0]         byte_index_next;
  logic [VALUE_W-1:0] pixel_accum_next;
  logic [CLW-1:0]     column_next;
  logic [DW-1:0]      row_next;

  // state as seen by this byte, after an optional start-of-image clear
  logic               eh_c, run_c, fin_c;
  logic [COUNT_W-1:0] left_c;
  logic [1:0]         bi_c;
  logic [VALUE_W-1:0] accum_c;
  logic [CLW-1:0]     col_c;
  logic [DW-1:0]      row_c;

  logic               emit, last_byte, pkt_done, res_done, res_over;
  logic [VALUE_W-1:0] accum_new;
  logic [COUNT_W-1:0] count, put;
  logic [DW-1:0]      row_sel;
  logic [TW-1:0]      base;
  logic [XW-1:0]      index_full, remain;
  logic [CLW-1:0]     col_sum;

  always_comb begin
    eh_c    = st_sof ? 1'b1 : expect_header;
    run_c   = st_sof ? 1'b0 : packet_is_run;
    fin_c   = st_sof ? 1'b0 : finished;
    left_c  = st_sof ? '0 : packet_left;
    bi_c    = st_sof ? '0 : byte_index;
    accum_c = st_sof ? ACCUM_INIT : pixel_accum;
    col_c   = st_sof ? '0 : column;
    row_c   = st_sof ? '0 : row;

    expect_header_next = eh_c;
    packet_is_run_next = run_c;
    finished_next      = fin_c;
    packet_left_next   = left_c;
    byte_index_next    = bi_c;
    pixel_accum_next   = accum_c;
    column_next        = col_c;
    row_next           = row_c;

    // byte lands in its lane, little-endian
    for (int i = 0; i < 4; i++) begin
      accum_new[8*i +: 8] = (bi_c == 2'(i)) ? st_byte : accum_c[8*i +: 8];
    end
    last_byte = (cfg_pixel_bytes == PIXEL_BYTES_3) ? (bi_c >= 2'd2) : (bi_c == 2'd3);

    // run takes the whole remaining count; a literal pixel counts one
    count = COUNT_W'(1);
    if (cfg_rle) begin
      if (run_c && left_c != '0) begin
        count = left_c;
      end
    end

    row_sel    = cfg_top_first ? row_c : DW'(h_dim - row_c - DW'(1));
    base       = TW'(row_sel) * TW'(w_dim);
    index_full = XW'(base) + XW'(col_c);
    remain     = XW'(total) - index_full;
    put        = count;
    res_over   = 1'b0;
    if (index_full >= XW'(total)) begin
      put      = '0;
      res_over = 1'b1;
    end else if (XW'(count) > remain) begin
      put      = COUNT_W'(remain);
      res_over = 1'b1;
    end

    col_sum  = col_c + CLW'(count);
    emit     = 1'b0;
    pkt_done = 1'b0;
    res_done = 1'b0;

    if (!fin_c) begin
      if (row_c >= h_dim) begin
        // height shrank under us: quietly finished
        finished_next = 1'b1;
      end else if (cfg_rle && eh_c) begin
        packet_is_run_next = st_byte[RUN_FLAG_BIT];
        packet_left_next   = COUNT_W'(st_byte[RUN_LEN_W-1:0]) + COUNT_W'(1);
        expect_header_next = 1'b0;
        byte_index_next    = '0;
        pixel_accum_next   = ACCUM_INIT;
      end else if (!last_byte) begin
        byte_index_next  = bi_c + 2'd1;
        pixel_accum_next = accum_new;
      end else begin
        emit             = 1'b1;
        byte_index_next  = '0;
        pixel_accum_next = ACCUM_INIT;
        if (cfg_rle) begin
          if (run_c && left_c != '0) begin
            packet_left_next = '0;
          end else if (left_c != '0) begin
            packet_left_next = left_c - COUNT_W'(1);
          end
          if (packet_left_next == '0) begin
            expect_header_next = 1'b1;
          end
        end
        pkt_done    = !cfg_rle || expect_header_next;
        column_next = col_sum;
        // excess past the row end is dropped, not carried
        if (pkt_done && col_sum >= CLW'(w_dim)) begin
          column_next = '0;
          row_next    = row_c + DW'(1);
          if (row_next >= h_dim) begin
            finished_next = 1'b1;
            res_done      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      packet_is_run <= 1'b0;
      finished      <= 1'b0;
      packet_left   <= '0;
      byte_index    <= '0;
      pixel_accum   <= ACCUM_INIT;
      column        <= '0;
      row           <= '0;
    end else if (adv) begin
      expect_header <= expect_header_next;
      packet_is_run <= packet_is_run_next;
      finished      <= finished_next;
      packet_left   <= packet_left_next;
      byte_index    <= byte_index_next;
      pixel_accum   <= pixel_accum_next;
      column        <= column_next;
      row           <= row_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_out.valid <= 1'b0;
    end else if (adv && emit) begin
      pixel_out.valid <= 1'b1;
    end else if (pixel_out.ready) begin
      pixel_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      pixel_out.pixel_index <= INDEX_W'(index_full);
      pixel_out.pixel_value <= accum_new;
      pixel_out.pixel_count <= put;
      pixel_out.image_done  <= res_done;
      pixel_out.overrun     <= res_over;
    end
  end

endmodule

/* sim/tga_rle_pixel_decoder_core_tb.sv */
module tga_rle_pixel_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trle_pkg::*;

  localparam int MAX_DIM      = 4096;
  // Give a little margin before touching registers.
  localparam int PIPE_CYCLES  = 2;
  localparam int SETTLE       = PIPE_CYCLES + 2;
  localparam int STALL_LIMIT  = 2000;
  localparam int TOTAL_ITEMS  = 1300;
  localparam int MAX_PRINTS   = 40;
  localparam int unsigned NO_CUT = 32'hFFFF_FFFF;

  // One expected pixel-run transaction on pixel_out.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               done;
    logic               over;
  } pixel_run_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  trle_byte_if byte_ch();
  trle_pix_if  pix_ch();

  tga_rle_pixel_decoder_core #(
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .byte_in  (byte_ch),
    .pixel_out(pix_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the header registers and of the decoder position state
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   fmt_width;
  logic [CFG_W-1:0]   fmt_height;
  logic [PB_W-1:0]    fmt_pbytes;
  logic               fmt_rle;
  logic               fmt_top;

  logic               want_header;
  logic               in_run;
  logic [7:0]         pkt_left;
  logic [1:0]         byte_pos;
  logic [VALUE_W-1:0] accum;
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic               img_finished;

  pixel_run_t  pixel_runs_due[$];
  int          errors;
  int          items_used;
  int          stall_cycles;
  bit          no_idle;
  bit          sof_next;     // start_of_image for the next byte that goes out
  int unsigned cut_left;     // bytes left before a stream is cut short

  task automatic clear_position();
    want_header  = 1'b1;
    in_run       = 1'b0;
    pkt_left     = '0;
    byte_pos     = '0;
    accum        = ACCUM_INIT;
    col_pos      = 0;
    row_pos      = 0;
    img_finished = 1'b0;
  endtask

  function automatic int unsigned dim_used(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned pixel_len();
    return (fmt_pbytes == PIXEL_BYTES_3) ? 3 : 4;
  endfunction

  // Advance the shadow decoder by one accepted byte and queue the pixel run
  // it produces, if any. used is low when the byte falls after a finished image.
  task automatic decode_byte(input logic [DATA_W-1:0] data, input logic sof, output bit used);
    int unsigned w, h, cnt, base, idx, total, put;
    logic [VALUE_W-1:0] pix;
    logic pkt_done;
    pixel_run_t res;
    used = 1'b0;
    if (sof) clear_position();
    if (img_finished) return;
    used = 1'b1;
    w = dim_used(fmt_width);
    h = dim_used(fmt_height);
    // height lowered under a running image: finishes silently
    if (row_pos >= h) begin
      img_finished = 1'b1;
      return;
    end
    if (fmt_rle && want_header) begin
      in_run      = data[RUN_FLAG_BIT];
      pkt_left    = {1'b0, data[RUN_LEN_W-1:0]} + 8'd1;
      want_header = 1'b0;
      byte_pos    = '0;
      accum       = ACCUM_INIT;
      return;
    end
    accum[8*byte_pos +: 8] = data;
    if (byte_pos + 1 < pixel_len()) begin
      byte_pos++;
      return;
    end
    byte_pos = '0;
    pix      = accum;
    accum    = ACCUM_INIT;

    cnt = 1;
    if (fmt_rle) begin
      if (in_run && pkt_left != 0) begin
        cnt      = pkt_left;
        pkt_left = '0;
      end else if (pkt_left != 0) begin
        pkt_left--;
      end
      if (pkt_left == 0) want_header = 1'b1;
    end
    pkt_done = !fmt_rle || want_header;

    base  = fmt_top ? row_pos * w : (h - row_pos - 1) * w;
    idx   = base + col_pos;
    total = w * h;
    put   = cnt;
    res.over = 1'b0;
    if (idx >= total) begin
      put      = 0;
      res.over = 1'b1;
    end else if (cnt > total - idx) begin
      put      = total - idx;
      res.over = 1'b1;
    end
    res.index = idx[INDEX_W-1:0];
    res.value = pix;
    res.count = put[COUNT_W-1:0];
    res.done  = 1'b0;

    // row moves on only at packet end, excess columns are dropped
    col_pos += cnt;
    if (pkt_done && col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        img_finished = 1'b1;
        res.done     = 1'b1;
      end
    end
    pixel_runs_due.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic bit gap_draw();
    return !no_idle && ($urandom_range(0, 99) < 22);
  endfunction

  // Result side stalls at random; one assignment per falling edge.
  always @(negedge clk) begin
    pix_ch.ready <= !gap_draw();
  end

  // Called and returns at a falling edge. valid stays high between
  // back-to-back bytes so it is never dropped and raised in one step.
  task automatic send_byte(input logic [DATA_W-1:0] data, input logic sof);
    bit used;
    while (gap_draw()) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid          <= 1'b1;
    byte_ch.data_byte      <= data;
    byte_ch.start_of_image <= sof;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(data, sof, used);
    if (used) items_used++;
    @(negedge clk);
  endtask

  // Byte source for the stream builders: handles image start and cut-off streams.
  task automatic emit(input logic [DATA_W-1:0] data);
    logic sof;
    if (cut_left == 0) return;
    cut_left--;
    sof      = sof_next;
    sof_next = 1'b0;
    send_byte(data, sof);
  endtask

  // Register write while the decoder is quiet; shadow follows.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:    fmt_width  = CFG_W'(val);
      REG_IMAGE_HEIGHT:   fmt_height = CFG_W'(val);
      REG_PIXEL_BYTES:    fmt_pbytes = PB_W'(val);
      REG_RLE_MODE:       fmt_rle    = val[0];
      REG_ROWS_TOP_FIRST: fmt_top    = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Hold the byte channel until every queued run has come out, then let
  // bytes that produce no result drain through the pipe.
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (pixel_runs_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_format(input int unsigned w, input int unsigned h, input int unsigned pb,
                            input bit rle, input bit top);
    set_reg(REG_IMAGE_WIDTH, w);
    set_reg(REG_IMAGE_HEIGHT, h);
    set_reg(REG_PIXEL_BYTES, pb);
    set_reg(REG_RLE_MODE, rle);
    set_reg(REG_ROWS_TOP_FIRST, top);
  endtask

  // ---------------------------------------------------------------------------
  // Stream builders
  // ---------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] pkt_header(input bit run, input int unsigned len);
    logic [DATA_W-1:0] hdr;
    hdr = '0;
    hdr[RUN_FLAG_BIT] = run;
    hdr[RUN_LEN_W-1:0] = RUN_LEN_W'(len - 1);
    return hdr;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // little-endian, 3 or 4 bytes as the current format says
  task automatic send_pixel(input logic [VALUE_W-1:0] value);
    for (int i = 0; i < pixel_len(); i++) emit(value[8*i +: 8]);
  endtask

  task automatic send_packet(input bit run, input int unsigned len);
    emit(pkt_header(run, len));
    if (run) send_pixel(rand_pixel());
    else repeat (len) send_pixel(rand_pixel());
  endtask

  // Well-formed image, built row by row; most packets stay inside a row,
  // some spill over the row end as a file may do.
  task automatic send_image();
    int unsigned w, h, left, len;
    w = dim_used(fmt_width);
    h = dim_used(fmt_height);
    sof_next = 1'b1;
    for (int r = 0; r < h; r++) begin
      left = w;
      while (left > 0) begin
        if (!fmt_rle) begin
          send_pixel(rand_pixel());
          left--;
        end else begin
          len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, (left < 128) ? left : 128)
                                           : $urandom_range(1, 128);
          send_packet($urandom_range(0, 1), len);
          left = (len >= left) ? 0 : left - len;
        end
      end
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 24);
    sof_next = $urandom_range(0, 1);
    repeat (n) begin
      emit(8'($urandom));
      sof_next = ($urandom_range(0, 9) == 0);
    end
    sof_next = 1'b0;
  endtask

  task automatic pick_format();
    int unsigned sel, w, h, pb;
    sel = $urandom_range(0, 99);
    w = (sel < 5) ? 0 : (sel < 15) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
    pb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
       : ($urandom_range(0, 1) ? PIXEL_BYTES_3 : PIXEL_BYTES_4);
    set_format(w, h, pb, $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    pixel_run_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pixel_runs_due.size() == 0) begin
        report_mismatch("pixel run with none pending, index", pix_ch.pixel_index, '0);
      end else begin
        want = pixel_runs_due.pop_front();
        check_field("pixel_index", pix_ch.pixel_index, want.index);
        check_field("pixel_value", pix_ch.pixel_value, want.value);
        check_field("pixel_count", pix_ch.pixel_count, want.count);
        check_field("image_done", pix_ch.image_done, want.done);
        check_field("overrun", pix_ch.overrun, want.over);
      end
    end
  end

  // Watchdog: any transaction or register write counts as progress.
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset format, then a short run-length image and a clipped run.
  task automatic test_defaults_and_packets();
    // reset format: 1x1, 4 bytes, raw, bottom-first
    sof_next = 1'b1;
    send_pixel(32'hA55A_FF00);
    emit(8'h7F);                       // past the image: dropped
    wait_idle();
    set_format(3, 2, PIXEL_BYTES_3, 1, 0);
    sof_next = 1'b1;
    emit(pkt_header(1'b1, 3));
    send_pixel(32'h0000_0000);
    emit(pkt_header(1'b0, 2));
    send_pixel(32'h00FF_FFFF);
    send_pixel(32'h0012_3456);
    emit(pkt_header(1'b1, 1));
    send_pixel(32'h0080_0001);
    wait_idle();
    // run longer than the whole image: clipped, overrun
    set_reg(REG_IMAGE_WIDTH, 2);
    set_reg(REG_IMAGE_HEIGHT, 1);
    set_reg(REG_ROWS_TOP_FIRST, 1);
    sof_next = 1'b1;
    emit(pkt_header(1'b1, 5));
    send_pixel(32'h00FF_FFFF);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    // zero sizes act as 1, odd pixel_bytes codes act as 4
    set_format(0, 0, 0, 0, 0);
    sof_next = 1'b1;
    send_pixel(rand_pixel());
    wait_idle();
    set_reg(REG_PIXEL_BYTES, 7);
    sof_next = 1'b1;
    send_pixel(rand_pixel());
    wait_idle();

    // oversized registers saturate to 4096x4096; walk the bottom row
    // (placed last) to its end, then a literal past the image end wraps
    // the 24-bit index
    set_format(8191, 8191, PIXEL_BYTES_3, 1, 0);
    sof_next = 1'b1;
    repeat (31) send_packet(1'b1, 128);
    send_packet(1'b1, 127);
    send_packet(1'b0, 3);
    send_packet(1'b1, 128);
    wait_idle();

    // literal packet across the end: later pixels start past the end
    set_format(2, 1, PIXEL_BYTES_4, 1, 1);
    sof_next = 1'b1;
    send_packet(1'b0, 4);
    emit(8'hC3);
    wait_idle();
  endtask

  task automatic test_restart_and_update();
    set_format(2, 3, PIXEL_BYTES_4, 0, 1);
    sof_next = 1'b1;
    repeat (4) send_pixel(rand_pixel());
    wait_idle();
    // height drops below the current row: finishes with no result
    set_reg(REG_IMAGE_HEIGHT, 2);
    send_pixel(rand_pixel());
    wait_idle();
    // restart in the middle of a pixel
    sof_next = 1'b1;
    emit(8'h11);
    emit(8'h22);
    sof_next = 1'b1;
    send_pixel(rand_pixel());
    wait_idle();
    // switch to run-length mid-image: raw mode left the header flag set
    set_reg(REG_RLE_MODE, 1);
    send_packet(1'b1, 2);
    send_packet(1'b0, 2);
    wait_idle();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (4) begin
      wait_idle();
      pick_format();
      send_image();
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_images();
    int unsigned pick;
    while (items_used < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) < 3) begin
        wait_idle();
        pick_format();
      end
      pick = $urandom_range(0, 99);
      cut_left = (pick < 10) ? $urandom_range(1, 30) : NO_CUT;
      if (pick >= 90) begin
        send_noise();
      end else begin
        send_image();
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) emit(8'($urandom));
      end
      cut_left = NO_CUT;
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = REG_IMAGE_WIDTH;
    cfg_data               = '0;
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = '0;
    byte_ch.start_of_image = 1'b0;
    pix_ch.ready           = 1'b0;
    errors       = 0;
    items_used   = 0;
    stall_cycles = 0;
    no_idle      = 1'b0;
    sof_next     = 1'b0;
    cut_left     = NO_CUT;
    fmt_width    = 1;
    fmt_height   = 1;
    fmt_pbytes   = PIXEL_BYTES_4;
    fmt_rle      = 1'b0;
    fmt_top      = 1'b0;
    clear_position();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_defaults_and_packets();
    test_register_extremes();
    test_restart_and_update();
    test_back_to_back();
    test_random_images();

    // all queued runs out, then a quiet spell to catch stray results
    wait_idle();
    repeat (4 * PIPE_CYCLES) @(negedge clk);
    if (errors == 0 && pixel_runs_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/trle_pkg.sv
rtl/core/trle_byte_if.sv
rtl/core/trle_pix_if.sv
rtl/core/tga_rle_pixel_decoder_core.sv
sim/tga_rle_pixel_decoder_core_tb.sv
